@@ sv/spq_pkg.sv @@
// spq_pkg: shared types, codes and sizes for the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] prio;
  } spq_entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic       push;
    logic       pop;
    spq_entry_t fresh;
  } spq_ctrl_t;

endpackage

@@ sv/spq_cell.sv @@
// spq_cell: one slot of the sorted row, compares the new item against its entry
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  spq_pkg::spq_entry_t left_entry,
  input  logic               left_valid,
  input  logic               left_ins,
  input  spq_pkg::spq_entry_t right_entry,
  input  logic               right_valid,
  output spq_pkg::spq_entry_t entry,
  output logic               valid,
  output logic               ins
);

  // new item lands here or further left; ties stay behind held entries
  assign ins = !valid || ($signed(ctrl.fresh.prio) < $signed(entry.prio));

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (ins) begin
        entry <= left_ins ? left_entry : ctrl.fresh;
      end
      valid <= valid | left_valid;
    end else if (ctrl.pop) begin
      entry <= right_entry;
      valid <= right_valid;
    end
    if (rst) begin
      valid <= 1'b0;
    end
  end

endmodule

@@ sv/sorted_priority_queue.sv @@
// sorted_priority_queue: top level, row of spq_cell slots plus result register
// depends on spq_pkg and spq_cell
//
// Bounded min-first priority queue of spq_pkg::CAPACITY entries, ties leave in
// arrival order. One operation is taken per clock: busy stays low, so an item
// is accepted on every edge where start is high. The result appears on the
// cycle after acceptance with done high for exactly that one cycle; the
// receiver cannot stall it and must take it then. The rate is one item per
// cycle, set by the row of cells, which all update in the same cycle with
// each cell doing one 32-bit signed compare against the broadcast new
// entry. Enqueue on a full queue and dequeue or peek on an empty one leave
// the queue unchanged and report full or empty status.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] payload,
  input  logic signed [31:0] priority_req,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] head_payload,
  output logic signed [31:0] head_priority,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  localparam int N = spq_pkg::CAPACITY;

  logic accept;
  spq_pkg::spq_ctrl_t ctrl;

  spq_pkg::spq_entry_t cell_entry [N];
  logic [N-1:0] cell_valid;
  logic [N-1:0] cell_ins;

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic        full;
  logic        empty;
  logic [1:0]  status_next;
  logic        take_head;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = cell_valid[N-1];
  assign empty  = !cell_valid[0];

  // decode the operation into row controls and the result fields
  always_comb begin
    ctrl.push        = 1'b0;
    ctrl.pop         = 1'b0;
    ctrl.fresh.payload = payload;
    ctrl.fresh.prio    = priority_req;
    count_next       = count;
    status_next      = spq_pkg::ST_OK;
    take_head        = 1'b0;
    unique case (operation)
      spq_pkg::OP_ENQ: begin
        if (full) begin
          status_next = spq_pkg::ST_FULL;
        end else begin
          ctrl.push  = accept;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::OP_DEQ: begin
        if (empty) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          ctrl.pop   = accept;
          take_head  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      spq_pkg::OP_PEEK: begin
        if (empty) begin
          status_next = spq_pkg::ST_EMPTY;
        end else begin
          take_head = 1'b1;
        end
      end
      default: begin
        // unused code: no change, ok status
      end
    endcase
  end

  // the row: each cell sees its left and right neighbor
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::spq_entry_t l_entry;
    spq_pkg::spq_entry_t r_entry;
    logic l_valid;
    logic l_ins;
    logic r_valid;

    if (i == 0) begin : g_first
      assign l_entry = ctrl.fresh;
      assign l_valid = 1'b1;
      assign l_ins   = 1'b0;
    end else begin : g_mid_l
      assign l_entry = cell_entry[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_ins   = cell_ins[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_entry = cell_entry[i];
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_entry = cell_entry[i+1];
      assign r_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_entry (l_entry),
      .left_valid (l_valid),
      .left_ins   (l_ins),
      .right_entry(r_entry),
      .right_valid(r_valid),
      .entry      (cell_entry[i]),
      .valid      (cell_valid[i]),
      .ins        (cell_ins[i])
    );
  end

  // count and the registered result
  always_ff @(posedge clk) begin
    done <= accept;
    if (accept) begin
      count         <= count_next;
      status        <= status_next;
      head_payload  <= take_head ? cell_entry[0].payload : 32'd0;
      head_priority <= take_head ? $signed(cell_entry[0].prio) : 32'sd0;
      entry_count   <= 5'(count_next);
      is_empty      <= (count_next == '0);
    end
    if (rst) begin
      done  <= 1'b0;
      count <= '0;
    end
  end

  // occupied slots form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied slots not contiguous");

  // the count tracks the occupied slots
  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == count)
    else $error("count disagrees with occupied slots");

  // head never ranks behind the second entry
  a_order: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> ($signed(cell_entry[0].prio) <= $signed(cell_entry[1].prio)))
    else $error("row out of order");

  // a dropped enqueue changes nothing
  a_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == spq_pkg::OP_ENQ) && full |=> $stable(count) && $stable(cell_valid))
    else $error("enqueue on full queue changed state");

endmodule
